// ===== rtl/dmrpi_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dmrpi_pkg;

	localparam int FRAC_BITS = 16;

	localparam int EL_W    = 20;
	localparam int ACC_W   = 20;
	localparam int GATE_W  = 16;
	localparam int TGT_W   = 20;
	localparam int MEAS_W  = 32;
	localparam int SPEED_W = 36;
	localparam int GOAL_W  = 48;
	localparam int WIDE_W  = 64;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = ACC_W;

	localparam logic [ACC_W-1:0]  ACC_RESET  = ACC_W'(9000);
	localparam logic [GATE_W-1:0] GATE_RESET = GATE_W'(200);

	// Input beat layout, lowest bit first.
	localparam int EL_LSB       = 0;
	localparam int LT_LSB       = EL_LSB + EL_W;
	localparam int RT_LSB       = LT_LSB + TGT_W;
	localparam int LM_LSB       = RT_LSB + TGT_W;
	localparam int RM_LSB       = LM_LSB + MEAS_W;
	localparam int IN_FIELDS_W  = RM_LSB + MEAS_W;
	localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_FIELDS_W = 2 * SPEED_W + 2 * GOAL_W;
	localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

	// Multiply and divide-by-a-million unit, one per lane and shared by both of its passes.
	localparam int USEC_PER_S = 1000000;
	localparam int MD_A_W     = SPEED_W;
	localparam int MD_B_W     = EL_W;
	localparam int PROD_W     = MD_A_W + MD_B_W;
	localparam int STEP_DVD_W = ACC_W + EL_W + FRAC_BITS;
	localparam int DVD_W      = (PROD_W > STEP_DVD_W) ? PROD_W : STEP_DVD_W;
	localparam int REM_W      = $clog2(USEC_PER_S);
	localparam int PRE_W      = REM_W - 1;
	localparam int QUO_W      = DVD_W - PRE_W;
	localparam int MD_CNT_W   = $clog2((QUO_W > MD_B_W) ? QUO_W : MD_B_W);
	localparam logic [REM_W:0] DIVISOR = (REM_W + 1)'(USEC_PER_S);

	typedef logic signed [WIDE_W-1:0] wide_t;

	localparam wide_t SPEED_MAX = (wide_t'(1) <<< (SPEED_W - 1)) - wide_t'(1);
	localparam wide_t SPEED_MIN = -SPEED_MAX - wide_t'(1);
	localparam wide_t GOAL_MAX  = (wide_t'(1) <<< (GOAL_W - 1)) - wide_t'(1);
	localparam wide_t GOAL_MIN  = -GOAL_MAX - wide_t'(1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ACCEL = 1'b0,
		REG_GATE  = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic              start;
		logic              scale;
		logic [MD_A_W-1:0] a;
		logic [MD_B_W-1:0] b;
	} md_req_t;

	typedef struct packed {
		logic             done;
		logic [QUO_W-1:0] quo;
	} md_rsp_t;

	typedef struct packed {
		logic start;
		logic align;
	} lane_cmd_t;

	function automatic logic signed [SPEED_W-1:0] sat_speed(input wide_t v);
		logic signed [SPEED_W-1:0] r;
		if (v > SPEED_MAX) begin
			r = SPEED_MAX[SPEED_W-1:0];
		end else if (v < SPEED_MIN) begin
			r = SPEED_MIN[SPEED_W-1:0];
		end else begin
			r = v[SPEED_W-1:0];
		end
		return r;
	endfunction

	function automatic logic signed [GOAL_W-1:0] sat_goal(input wide_t v);
		logic signed [GOAL_W-1:0] r;
		if (v > GOAL_MAX) begin
			r = GOAL_MAX[GOAL_W-1:0];
		end else if (v < GOAL_MIN) begin
			r = GOAL_MIN[GOAL_W-1:0];
		end else begin
			r = v[GOAL_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/dmrpi_muldiv.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dmrpi_muldiv
	import dmrpi_pkg::*;
(
	input  wire     clk,
	input  wire     arst_n,
	input  md_req_t req,
	output md_rsp_t rsp
);

	typedef enum logic [3:0] {
		MD_IDLE = 4'b0001,
		MD_MUL  = 4'b0010,
		MD_LOAD = 4'b0100,
		MD_DIV  = 4'b1000
	} md_state_t;

	md_state_t           state_q;
	logic [MD_CNT_W-1:0] cnt_q;
	logic                done_q;
	logic [MD_A_W-1:0]   a_q;
	logic                scale_q;
	logic [PROD_W:0]     mp_q;
	logic [REM_W-1:0]    rem_q;
	logic [QUO_W-1:0]    dq_q;

	logic [MD_A_W:0]     mp_sum;
	logic [DVD_W-1:0]    dvd;
	logic [REM_W:0]      trial;
	logic                trial_ge;

	// The product builds up one multiplier bit a cycle, least significant first; the
	// quotient then comes out one bit a cycle by restoring division.
	always_comb begin
		mp_sum = mp_q[PROD_W:MD_B_W] + {1'b0, a_q};
		dvd = DVD_W'(mp_q[PROD_W-1:0]);
		if (scale_q) begin
			dvd = dvd << FRAC_BITS;
		end
		trial = {rem_q, dq_q[QUO_W-1]};
		trial_ge = (trial >= DIVISOR);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MD_IDLE;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				MD_IDLE: begin
					if (req.start) begin
						state_q <= MD_MUL;
						cnt_q <= MD_CNT_W'(MD_B_W - 1);
					end
				end
				MD_MUL: begin
					if (cnt_q == '0) begin
						state_q <= MD_LOAD;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				MD_LOAD: begin
					state_q <= MD_DIV;
					cnt_q <= MD_CNT_W'(QUO_W - 1);
				end
				MD_DIV: begin
					if (cnt_q == '0) begin
						state_q <= MD_IDLE;
						done_q <= 1'b1;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				default: begin
					state_q <= MD_IDLE;
				end
			endcase
		end
	end

	// The top bits of the dividend are below the divisor, so they preload the remainder.
	always_ff @(posedge clk) begin
		if (state_q == MD_IDLE && req.start) begin
			a_q <= req.a;
			scale_q <= req.scale;
			mp_q <= {{(MD_A_W + 1){1'b0}}, req.b};
		end
		if (state_q == MD_MUL) begin
			if (mp_q[0]) begin
				mp_q <= {1'b0, mp_sum, mp_q[MD_B_W-1:1]};
			end else begin
				mp_q <= {1'b0, mp_q[PROD_W:1]};
			end
		end
		if (state_q == MD_LOAD) begin
			rem_q <= REM_W'(dvd[DVD_W-1 -: PRE_W]);
			dq_q <= dvd[QUO_W-1:0];
		end
		if (state_q == MD_DIV) begin
			rem_q <= trial_ge ? REM_W'(trial - DIVISOR) : REM_W'(trial);
			dq_q <= {dq_q[QUO_W-2:0], trial_ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo = dq_q;

endmodule

`default_nettype wire

// ===== rtl/dmrpi_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dmrpi_lane
	import dmrpi_pkg::*;
(
	input  wire                      clk,
	input  wire                      arst_n,
	input  lane_cmd_t                cmd,
	input  wire [EL_W-1:0]           elapsed,
	input  wire signed [TGT_W-1:0]   target,
	input  wire signed [MEAS_W-1:0]  meas,
	input  wire [ACC_W-1:0]          acc,
	input  wire [GATE_W-1:0]         gate,
	output logic signed [SPEED_W-1:0] speed,
	output logic signed [GOAL_W-1:0]  goal,
	output logic                     busy
);

	typedef enum logic [4:0] {
		L_IDLE  = 5'b00001,
		L_STEP  = 5'b00010,
		L_RAMP  = 5'b00100,
		L_INCGO = 5'b01000,
		L_INC   = 5'b10000
	} lane_state_t;

	lane_state_t               state_q;
	logic signed [SPEED_W-1:0] speed_q;
	logic signed [GOAL_W-1:0]  goal_q;
	logic signed [SPEED_W-1:0] tgt_q;
	logic signed [MEAS_W-1:0]  meas_q;
	logic [EL_W-1:0]           el_q;
	logic                      gate_ok_q;
	logic                      neg_q;

	md_req_t                   md_req;
	md_rsp_t                   md_rsp;

	wide_t                     diff;
	wide_t                     step_w;
	wide_t                     gap;
	wide_t                     gate_w;
	wide_t                     inc_w;
	logic signed [SPEED_W-1:0] speed_next;
	logic [SPEED_W-1:0]        speed_mag;
	logic                      gate_ok;

	dmrpi_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (md_req),
		.rsp    (md_rsp)
	);

	always_comb begin
		diff = wide_t'(speed_q) - wide_t'(tgt_q);
		step_w = wide_t'(md_rsp.quo);
		if (diff <= step_w && diff >= -step_w) begin
			speed_next = tgt_q;
		end else if (diff > step_w) begin
			speed_next = SPEED_W'(wide_t'(speed_q) - step_w);
		end else begin
			speed_next = SPEED_W'(wide_t'(speed_q) + step_w);
		end

		// Integration is allowed only while the goal stays strictly inside the gate.
		gap = wide_t'(goal_q) - (wide_t'(meas_q) <<< FRAC_BITS);
		gate_w = wide_t'(gate) <<< FRAC_BITS;
		gate_ok = (gap < gate_w) && (gap > -gate_w);

		speed_mag = speed_q[SPEED_W-1] ? SPEED_W'(-speed_q) : speed_q;
		inc_w = neg_q ? -wide_t'(md_rsp.quo) : wide_t'(md_rsp.quo);

		md_req.start = ((state_q == L_IDLE) && cmd.start && !cmd.align)
			|| (state_q == L_INCGO);
		md_req.scale = (state_q == L_IDLE);
		md_req.a = (state_q == L_IDLE) ? MD_A_W'(acc) : speed_mag;
		md_req.b = (state_q == L_IDLE) ? elapsed : el_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
			speed_q <= '0;
			goal_q <= '0;
		end else begin
			unique case (state_q)
				L_IDLE: begin
					if (cmd.start) begin
						if (cmd.align) begin
							goal_q <= sat_goal(wide_t'(meas) <<< FRAC_BITS);
						end else begin
							state_q <= L_STEP;
						end
					end
				end
				L_STEP: begin
					if (md_rsp.done) begin
						state_q <= L_RAMP;
					end
				end
				L_RAMP: begin
					speed_q <= speed_next;
					state_q <= L_INCGO;
				end
				L_INCGO: begin
					state_q <= L_INC;
				end
				L_INC: begin
					if (md_rsp.done) begin
						if (gate_ok_q) begin
							goal_q <= sat_goal(wide_t'(goal_q) + inc_w);
						end
						state_q <= L_IDLE;
					end
				end
				default: begin
					state_q <= L_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == L_IDLE && cmd.start) begin
			tgt_q <= sat_speed(wide_t'(target) <<< FRAC_BITS);
			meas_q <= meas;
			el_q <= elapsed;
		end
		if (state_q == L_RAMP) begin
			gate_ok_q <= gate_ok;
		end
		if (state_q == L_INCGO) begin
			neg_q <= speed_q[SPEED_W-1];
		end
	end

	assign speed = speed_q;
	assign goal = goal_q;
	assign busy = (state_q != L_IDLE);

endmodule

`default_nettype wire

// ===== rtl/dual_motor_ramp_position_integrator_unit.sv =====
// Speed ramp and gated goal-position integrator for two motors. Each input beat is a
// control tick or, with s_tuser set, an align request that copies the measured positions
// into the goals. A tick makes two passes through each motor's bit-serial multiply and
// divide-by-a-million unit (20 multiply steps and 37 quotient bits per pass), the first for
// the acceleration step and the second for the position increment. One item is worked on at
// a time, and a new beat is taken while the previous result still waits on the output.
// Configuration writes are taken in any cycle and must be made while idle.
`timescale 1ns / 1ps
`default_nettype none

module dual_motor_ramp_position_integrator_unit
	import dmrpi_pkg::*;
(
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  s_tvalid,
	output logic                 s_tready,
	// elapsed_us, left_target_speed, right_target_speed, left_measured_position,
	// right_measured_position, zero padding
	input  wire [IN_DATA_W-1:0]  s_tdata,
	// action
	input  wire                  s_tuser,
	output logic                 m_tvalid,
	input  wire                  m_tready,
	// left_speed, right_speed, left_goal_position, right_goal_position
	output logic [OUT_DATA_W-1:0] m_tdata,
	input  wire                  cfg_valid,
	output logic                 cfg_ready,
	input  wire [CFG_IDX_W-1:0]  cfg_index,
	input  wire [CFG_DATA_W-1:0] cfg_data
);

	typedef enum logic [2:0] {
		T_IDLE = 3'b001,
		T_BUSY = 3'b010,
		T_PEND = 3'b100
	} top_state_t;

	top_state_t                state_q;
	logic [ACC_W-1:0]          acc_q;
	logic [GATE_W-1:0]         gate_q;
	logic                      m_tvalid_q;
	logic [OUT_DATA_W-1:0]     m_tdata_q;

	logic                      accept;
	logic                      load;
	lane_cmd_t                 lane_cmd;
	logic signed [SPEED_W-1:0] l_speed;
	logic signed [SPEED_W-1:0] r_speed;
	logic signed [GOAL_W-1:0]  l_goal;
	logic signed [GOAL_W-1:0]  r_goal;
	logic                      l_busy;
	logic                      r_busy;

	assign s_tready = (state_q == T_IDLE);
	assign accept = s_tvalid && s_tready;
	assign lane_cmd.start = accept;
	assign lane_cmd.align = s_tuser;
	assign cfg_ready = 1'b1;

	assign load = (((state_q == T_BUSY) && !l_busy && !r_busy) || (state_q == T_PEND))
		&& (!m_tvalid_q || m_tready);

	dmrpi_lane u_left (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (lane_cmd),
		.elapsed (s_tdata[EL_LSB +: EL_W]),
		.target  (s_tdata[LT_LSB +: TGT_W]),
		.meas    (s_tdata[LM_LSB +: MEAS_W]),
		.acc     (acc_q),
		.gate    (gate_q),
		.speed   (l_speed),
		.goal    (l_goal),
		.busy    (l_busy)
	);

	dmrpi_lane u_right (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (lane_cmd),
		.elapsed (s_tdata[EL_LSB +: EL_W]),
		.target  (s_tdata[RT_LSB +: TGT_W]),
		.meas    (s_tdata[RM_LSB +: MEAS_W]),
		.acc     (acc_q),
		.gate    (gate_q),
		.speed   (r_speed),
		.goal    (r_goal),
		.busy    (r_busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= ACC_RESET;
			gate_q <= GATE_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_ACCEL: begin
					acc_q <= cfg_data[ACC_W-1:0];
				end
				REG_GATE: begin
					gate_q <= cfg_data[GATE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// The result waits in the lanes when the output register is still full.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			if (load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				T_IDLE: begin
					if (accept) begin
						state_q <= T_BUSY;
					end
				end
				T_BUSY: begin
					if (load) begin
						state_q <= T_IDLE;
					end else if (!l_busy && !r_busy) begin
						state_q <= T_PEND;
					end
				end
				T_PEND: begin
					if (load) begin
						state_q <= T_IDLE;
					end
				end
				default: begin
					state_q <= T_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			m_tdata_q <= OUT_DATA_W'({r_goal, l_goal, r_speed, l_speed});
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;

endmodule

`default_nettype wire
